// ----- src/cst_pkg.sv -----
package cst_pkg;

   // field widths of one table entry
   localparam int KEY_W   = 8;
   localparam int COUNT_W = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // width of index fields on the result channel
   localparam int OUT_IDX_W = 5;

   // request kinds
   typedef enum logic [2:0] {
      KIND_ADD    = 3'd0,
      KIND_REMOVE = 3'd1,
      KIND_NEXT   = 3'd2,
      KIND_PREV   = 3'd3,
      KIND_UP     = 3'd4,
      KIND_DOWN   = 3'd5
   } kind_type;

   // register indexes on the configuration port
   localparam logic REG_ROW_WIDTH = 1'b0;

   // scan result flags handed from the compare unit to the sequencer
   typedef struct packed {
      logic               match_found;
      logic               empty_found;
      logic [COUNT_W-1:0] match_count;
   } scan_flags_type;

endpackage

// ----- src/cst_table.sv -----
module cst_table import cst_pkg::*; #(
   parameter int SLOTS = 32,
   parameter int IDX_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [KEY_W-1:0]   rd_key,
   output logic [COUNT_W-1:0] rd_count,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [KEY_W-1:0]   wr_key,
   input  logic [COUNT_W-1:0] wr_count
);

   logic [KEY_W-1:0]   key_mem   [SLOTS];
   logic [COUNT_W-1:0] count_mem [SLOTS];
   logic [SLOTS-1:0]   valid_ff;
   logic [SLOTS-1:0]   valid_in;
   logic               rd_valid_ff;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [COUNT_W-1:0] rd_count_ff;

   // entry written at least once since reset
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         count_mem[wr_addr] <= wr_count;
      end
      rd_valid_ff <= valid_ff[rd_addr];
      rd_key_ff   <= key_mem[rd_addr];
      rd_count_ff <= count_mem[rd_addr];
   end

   // unwritten entries read as empty
   assign rd_key   = rd_valid_ff ? rd_key_ff : '0;
   assign rd_count = rd_valid_ff ? rd_count_ff : '0;

endmodule

// ----- src/cst_scan.sv -----
module cst_scan import cst_pkg::*; #(
   parameter int IDX_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               issue_valid,
   input  logic [IDX_W-1:0]   issue_idx,
   input  logic [KEY_W-1:0]   target_key,
   input  logic [KEY_W-1:0]   rd_key,
   input  logic [COUNT_W-1:0] rd_count,
   output scan_flags_type     flags,
   output logic [IDX_W-1:0]   match_idx,
   output logic [IDX_W-1:0]   empty_idx
);

   logic               tag_valid_ff;
   logic               tag_valid_in;
   logic [IDX_W-1:0]   tag_idx_ff;
   scan_flags_type     flags_ff;
   scan_flags_type     flags_in;
   logic [IDX_W-1:0]   match_idx_ff;
   logic [IDX_W-1:0]   match_idx_in;
   logic [IDX_W-1:0]   empty_idx_ff;
   logic [IDX_W-1:0]   empty_idx_in;
   logic               key_hit;
   logic               key_empty;

   // the shared key compare, one entry per cycle
   assign key_hit   = (rd_key == target_key);
   assign key_empty = (rd_key == '0);
   assign tag_valid_in = issue_valid;

   // keep the lowest matching and the lowest empty entry
   always_comb begin
      flags_in     = flags_ff;
      match_idx_in = match_idx_ff;
      empty_idx_in = empty_idx_ff;
      if (clear) begin
         flags_in = '0;
      end else if (tag_valid_ff) begin
         if (key_hit && !flags_ff.match_found) begin
            flags_in.match_found = 1'b1;
            flags_in.match_count = rd_count;
            match_idx_in         = tag_idx_ff;
         end
         if (key_empty && !flags_ff.empty_found) begin
            flags_in.empty_found = 1'b1;
            empty_idx_in         = tag_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         tag_valid_ff <= tag_valid_in;
         flags_ff     <= flags_in;
      end
      tag_idx_ff   <= issue_idx;
      match_idx_ff <= match_idx_in;
      empty_idx_ff <= empty_idx_in;
   end

   assign flags     = flags_ff;
   assign match_idx = match_idx_ff;
   assign empty_idx = empty_idx_ff;

endmodule

// ----- src/counted_slot_table_with_cursor.sv -----
// channel   | dir | handshake          | payload
// req_      | in  | tvalid / tready    | tdata: item_key, initial_count; tuser: kind
// rsp_      | out | tvalid / tready    | tdata: touched, index, key, count; tuser: ok
// csr_      | in  | psel / penable     | row_width at byte address 0
//
// add and remove scan every slot through one compare unit, one slot per cycle,
// then decide and write back, read the cursor slot and register the result;
// cursor moves and unused kinds skip the scan and go to the cursor slot read
// req_tready is high only while idle; a waiting result holds the last step
// reset clears cursor and every slot's valid bit and sets row width to 5
module counted_slot_table_with_cursor import cst_pkg::*; #(
   parameter int SLOTS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // item_key [7:0], initial_count [23:8]
   input  logic [2:0]   req_tuser,   // kind [2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // slot_touched [4:0], selected_index [9:5],
                                     // selected_key [17:10], selected_count [33:18]
   output logic [0:0]   rsp_tuser,   // ok [0]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = IDX_W + 1;
   localparam int RW_W  = 6;
   localparam int RW_N  = 1 << RW_W;
   localparam logic [CW-1:0] SLOTS_V = CW'(SLOTS);
   localparam logic [RW_W-1:0] ROW_WIDTH_RST = RW_W'(5);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_CUR_RD,
      ST_CUR_WAIT
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cursor_ff, cursor_in;
   logic [2:0]         kind_ff, kind_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [COUNT_W-1:0] init_ff, init_in;
   logic [CW-1:0]      scan_cnt_ff, scan_cnt_in;
   logic               ok_ff, ok_in;
   logic [IDX_W-1:0]   touched_ff, touched_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [RW_W-1:0]    row_width_ff, row_width_in;

   logic [IDX_W-1:0]   step_tab [RW_N];
   logic [IDX_W-1:0]   step;
   logic [CW-1:0]      cur_ext;
   logic [CW-1:0]      step_ext;
   logic [CW-1:0]      cur_sum;
   logic [IDX_W-1:0]   cursor_move;

   logic               req_xfer;
   logic               csr_write;
   logic               scan_clear;
   logic               issue_valid;
   logic [IDX_W-1:0]   rd_addr;
   logic [KEY_W-1:0]   rd_key;
   logic [COUNT_W-1:0] rd_count;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [KEY_W-1:0]   wr_key;
   logic [COUNT_W-1:0] wr_count;
   scan_flags_type     flags;
   logic [IDX_W-1:0]   match_idx;
   logic [IDX_W-1:0]   empty_idx;
   logic               out_free;
   logic [IDX_W+4:0]   touched_wide;
   logic [IDX_W+4:0]   index_wide;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ROW_WIDTH) ? {26'd0, row_width_ff} : '0;

   always_comb begin
      row_width_in = row_width_ff;
      if (csr_write && (csr_paddr[2] == REG_ROW_WIDTH)) begin
         row_width_in = csr_pwdata[RW_W-1:0];
      end
   end

   // row width reduced modulo the table size
   for (genvar g = 0; g < RW_N; g++) begin : g_step
      assign step_tab[g] = IDX_W'(g % SLOTS);
   end
   assign step = step_tab[row_width_ff];

   // cursor arithmetic for the four move kinds
   assign cur_ext  = {1'b0, cursor_ff};
   assign step_ext = {1'b0, step};
   always_comb begin
      cur_sum = cur_ext;
      unique case (req_tuser)
         KIND_NEXT: begin
            cur_sum = (cur_ext + CW'(1) >= SLOTS_V) ? '0 : cur_ext + CW'(1);
         end
         KIND_PREV: begin
            cur_sum = (cur_ext == '0) ? SLOTS_V - CW'(1) : cur_ext - CW'(1);
         end
         KIND_UP: begin
            cur_sum = (cur_ext >= step_ext) ? cur_ext - step_ext
                                            : cur_ext + SLOTS_V - step_ext;
         end
         KIND_DOWN: begin
            cur_sum = (cur_ext + step_ext >= SLOTS_V) ? cur_ext + step_ext - SLOTS_V
                                                      : cur_ext + step_ext;
         end
         default: begin
            cur_sum = cur_ext;
         end
      endcase
   end
   assign cursor_move = cur_sum[IDX_W-1:0];

   // table storage and the shared scan compare
   assign rd_addr = (state_ff == ST_SCAN) ? scan_cnt_ff[IDX_W-1:0] : cursor_ff;

   cst_table #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_count (rd_count),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_count (wr_count)
   );

   cst_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (scan_clear),
      .issue_valid (issue_valid),
      .issue_idx   (scan_cnt_ff[IDX_W-1:0]),
      .target_key  (key_ff),
      .rd_key      (rd_key),
      .rd_count    (rd_count),
      .flags       (flags),
      .match_idx   (match_idx),
      .empty_idx   (empty_idx)
   );

   // result packing
   assign touched_wide = {5'd0, touched_ff};
   assign index_wide   = {5'd0, cursor_ff};
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_xfer     = req_tvalid && req_tready;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      init_in     = init_ff;
      scan_cnt_in = scan_cnt_ff;
      ok_in       = ok_ff;
      touched_in  = touched_ff;
      rsp_data_in = rsp_data_ff;
      rsp_ok_in   = rsp_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      scan_clear  = 1'b0;
      issue_valid = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = match_idx;
      wr_key      = key_ff;
      wr_count    = flags.match_count;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               kind_in     = req_tuser;
               key_in      = req_tdata[7:0];
               init_in     = req_tdata[23:8];
               touched_in  = '0;
               scan_cnt_in = '0;
               if (req_tuser == KIND_ADD || req_tuser == KIND_REMOVE) begin
                  scan_clear = 1'b1;
                  ok_in      = 1'b0;
                  state_in   = ST_SCAN;
               end else begin
                  cursor_in = cursor_move;
                  ok_in     = (req_tuser == KIND_NEXT) || (req_tuser == KIND_PREV) ||
                              (req_tuser == KIND_UP) || (req_tuser == KIND_DOWN);
                  state_in  = ST_CUR_RD;
               end
            end
         end
         ST_SCAN: begin
            // last read lands in the cycle after the last address
            if (scan_cnt_ff < SLOTS_V) begin
               issue_valid = 1'b1;
               scan_cnt_in = scan_cnt_ff + CW'(1);
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_CUR_RD;
            if (kind_ff == KIND_ADD) begin
               if (key_ff != '0 && flags.match_found) begin
                  wr_en      = 1'b1;
                  wr_count   = (flags.match_count == COUNT_MAX) ? COUNT_MAX
                                                                : flags.match_count +
                                                                  COUNT_W'(1);
                  ok_in      = 1'b1;
                  touched_in = match_idx;
               end else if (key_ff != '0 && flags.empty_found) begin
                  wr_en      = 1'b1;
                  wr_addr    = empty_idx;
                  wr_count   = init_ff;
                  ok_in      = 1'b1;
                  touched_in = empty_idx;
               end
            end else if (flags.match_found) begin
               // remove: clear the slot once its count runs out
               wr_en      = 1'b1;
               ok_in      = 1'b1;
               touched_in = match_idx;
               if (flags.match_count <= COUNT_W'(1)) begin
                  wr_key   = '0;
                  wr_count = '0;
               end else begin
                  wr_count = flags.match_count - COUNT_W'(1);
               end
            end
         end
         ST_CUR_RD: begin
            state_in = ST_CUR_WAIT;
         end
         ST_CUR_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_data_in  = {6'd0, rd_count, rd_key, index_wide[4:0],
                               ok_ff ? touched_wide[4:0] : 5'd0};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         row_width_ff <= ROW_WIDTH_RST;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         row_width_ff <= row_width_in;
      end
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      init_ff     <= init_in;
      scan_cnt_ff <= scan_cnt_in;
      ok_ff       <= ok_in;
      touched_ff  <= touched_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

endmodule

// ----- src/cst_checker.sv -----
module cst_checker import cst_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [23:0]  req_tdata,
   input logic [2:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a failed request touches no slot
   a_fail_touch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[4:0] == 5'd0)
      else $error("failed request reports a touched slot");

   // an empty slot has no count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:10] == 8'd0 |-> rsp_tdata[33:18] == 16'd0)
      else $error("empty slot with nonzero count");

endmodule

bind counted_slot_table_with_cursor cst_checker u_cst_checker (.*);

// ----- tb/sv/tb_top.sv -----
module tb_top;
   import cst_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int SLOT_COUNT   = 32;
   // time to let the block finish a table scan after the last result
   localparam int SCAN_SETTLE  = SLOT_COUNT + 8;
   localparam logic [2:0] ROW_WIDTH_ADDR = 3'(4 * REG_ROW_WIDTH);
   // request kinds with no function, the block must answer them with ok low
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                 ok;
      logic [OUT_IDX_W-1:0] touched;
      logic [OUT_IDX_W-1:0] index;
      logic [KEY_W-1:0]     key;
      logic [COUNT_W-1:0]   count;
   } slot_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [23:0]  req_tdata;   // item_key [7:0], initial_count [23:8]
   logic [2:0]   req_tuser;   // kind [2:0]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;   // slot_touched [4:0], selected_index [9:5],
                              // selected_key [17:10], selected_count [33:18]
   logic [0:0]   rsp_tuser;   // ok [0]
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // shadow copy of the slot table, cursor and row width
   logic [KEY_W-1:0]     slot_key_q [SLOT_COUNT];
   logic [COUNT_W-1:0]   slot_count_q [SLOT_COUNT];
   logic [OUT_IDX_W-1:0] cursor_q;
   logic [5:0]           row_width_q;

   slot_result_type pending_results[$];
   slot_result_type want;

   bit no_idle;
   int stall_left;
   int fail_count;
   int n_requests, n_add_stored, n_add_refused, n_saturated, n_freed, n_moves, n_settings;

   counted_slot_table_with_cursor #(
      .SLOTS(SLOT_COUNT)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // idle length for either side: mostly none or short, now and then long
   function automatic int next_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // table update for one request, returns the result the block must send
   function automatic slot_result_type apply_request(logic [2:0] kind,
                                                     logic [KEY_W-1:0] key,
                                                     logic [COUNT_W-1:0] init);
      slot_result_type res;
      int hit;
      res = '0;
      hit = -1;
      case (kind)
         KIND_ADD: begin
            if (key != '0) begin
               for (int i = 0; i < SLOT_COUNT; i++)
                  if (hit < 0 && slot_key_q[i] == key) hit = i;
               if (hit >= 0) begin
                  if (slot_count_q[hit] != COUNT_MAX) slot_count_q[hit]++;
                  else n_saturated++;
               end else begin
                  // claim the lowest empty slot
                  for (int i = 0; i < SLOT_COUNT; i++)
                     if (hit < 0 && slot_key_q[i] == '0) hit = i;
                  if (hit >= 0) begin
                     slot_key_q[hit]   = key;
                     slot_count_q[hit] = init;
                     n_add_stored++;
                  end else begin
                     n_add_refused++;
                  end
               end
            end
         end
         KIND_REMOVE: begin
            // key 0 hits the lowest empty slot, which stays empty
            for (int i = 0; i < SLOT_COUNT; i++)
               if (hit < 0 && slot_key_q[i] == key) hit = i;
            if (hit >= 0) begin
               if (slot_count_q[hit] <= COUNT_W'(1)) begin
                  if (slot_key_q[hit] != '0) n_freed++;
                  slot_key_q[hit]   = '0;
                  slot_count_q[hit] = '0;
               end else begin
                  slot_count_q[hit]--;
               end
            end
         end
         // with 32 slots the 5-bit cursor wraps by itself
         KIND_NEXT: cursor_q = cursor_q + OUT_IDX_W'(1);
         KIND_PREV: cursor_q = cursor_q - OUT_IDX_W'(1);
         KIND_UP:   cursor_q = cursor_q - row_width_q[OUT_IDX_W-1:0];
         KIND_DOWN: cursor_q = cursor_q + row_width_q[OUT_IDX_W-1:0];
         default: ;
      endcase
      if (kind inside {KIND_NEXT, KIND_PREV, KIND_UP, KIND_DOWN}) begin
         res.ok = 1'b1;
         n_moves++;
      end else if (hit >= 0) begin
         res.ok      = 1'b1;
         res.touched = OUT_IDX_W'(hit);
      end
      res.index = cursor_q;
      res.key   = slot_key_q[cursor_q];
      res.count = slot_count_q[cursor_q];
      return res;
   endfunction

   // one request transfer, valid stays high when the next follows at once
   task automatic send_request(input logic [2:0] kind, input logic [KEY_W-1:0] key,
                               input logic [COUNT_W-1:0] init);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {init, key};
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_results.push_back(apply_request(kind, key, init));
      n_requests++;
   endtask

   // stop sending and let every outstanding result and scan finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SCAN_SETTLE) @(posedge clock);
   endtask

   // write row width while idle, then read it back
   task automatic set_row_width(input logic [5:0] value);
      logic [31:0] seen;
      wait_idle();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ROW_WIDTH_ADDR;
      csr_pwdata  <= {26'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      row_width_q = value;
      n_settings++;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      seen = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (seen !== {26'd0, row_width_q}) begin
         $error("row_width: expected %0d, actual %0d", row_width_q, seen);
         fail_count++;
      end
   endtask

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser[0] !== want.ok) begin
               $error("ok: expected %0d, actual %0d", want.ok, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tdata[4:0] !== want.touched) begin
               $error("slot_touched: expected %0d, actual %0d", want.touched, rsp_tdata[4:0]);
               fail_count++;
            end
            if (rsp_tdata[9:5] !== want.index) begin
               $error("selected_index: expected %0d, actual %0d", want.index, rsp_tdata[9:5]);
               fail_count++;
            end
            if (rsp_tdata[17:10] !== want.key) begin
               $error("selected_key: expected %0d, actual %0d", want.key, rsp_tdata[17:10]);
               fail_count++;
            end
            if (rsp_tdata[33:18] !== want.count) begin
               $error("selected_count: expected %0d, actual %0d", want.count,
                      rsp_tdata[33:18]);
               fail_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = next_gap();
         rsp_tready <= (stall_left == 0);
      end
   end

   // empty table cases, field extremes, saturation, clearing, spare kinds
   task automatic test_table_basics();
      send_request(KIND_ADD, 8'h00, 16'd1234);
      send_request(KIND_REMOVE, 8'h00, 16'h0000);
      send_request(KIND_ADD, 8'hFF, 16'hFFFF);
      send_request(KIND_ADD, 8'hFF, 16'h0000);
      send_request(KIND_ADD, 8'h01, 16'h0000);
      send_request(KIND_REMOVE, 8'h01, 16'hFFFF);
      send_request(KIND_ADD, 8'hA5, 16'h0001);
      send_request(KIND_REMOVE, 8'hFF, 16'h5A5A);
      send_request(KIND_REMOVE, 8'h77, 16'h0000);
      send_request(KIND_SPARE_LO, 8'hFF, 16'hFFFF);
      send_request(KIND_SPARE_HI, 8'hA5, 16'h0001);
   endtask

   // every move kind with wrap in both directions and each extreme row width
   task automatic test_cursor_moves();
      logic [5:0] widths [5] = '{6'd0, 6'd63, 6'd32, 6'd31, 6'd1};
      send_request(KIND_PREV, 8'h00, 16'h0000);
      send_request(KIND_NEXT, 8'h00, 16'h0000);
      send_request(KIND_NEXT, 8'hFF, 16'hFFFF);
      send_request(KIND_UP, 8'h00, 16'h0000);
      send_request(KIND_DOWN, 8'h00, 16'h0000);
      foreach (widths[i]) begin
         set_row_width(widths[i]);
         send_request(KIND_UP, 8'($urandom_range(0, 255)), 16'($urandom));
         send_request(KIND_DOWN, 8'($urandom_range(0, 255)), 16'($urandom));
      end
   endtask

   // fill every slot, get refused, then free what was stored
   task automatic test_full_table();
      for (int k = 101; k <= 140; k++)
         send_request(KIND_ADD, 8'(k), 16'($urandom_range(0, 1)));
      send_request(KIND_REMOVE, 8'h00, 16'h0000);
      send_request(KIND_ADD, 8'd120, 16'($urandom));
      for (int k = 101; k <= 140; k++)
         send_request(KIND_REMOVE, 8'(k), 16'($urandom));
      // sender holds off until the block has nothing left in flight
      wait_idle();
   endtask

   // mixed traffic over many row widths and key pools
   task automatic test_random_traffic();
      int pools [4] = '{6, 24, 48, 255};
      logic [5:0] widths [6] = '{6'd5, 6'd0, 6'd63, 6'd32, 6'd1, 6'd31};
      logic [2:0] kind;
      logic [KEY_W-1:0] key;
      logic [COUNT_W-1:0] init;
      int pool, r;
      for (int phase = 0; phase < 10; phase++) begin
         set_row_width(phase < 6 ? widths[phase] : 6'($urandom_range(0, 63)));
         pool = pools[phase % 4];
         no_idle = ($urandom_range(0, 4) == 0);
         for (int n = 0; n < 80; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) kind = KIND_ADD;
            else if (r < 68) kind = KIND_REMOVE;
            else if (r < 95) kind = 3'(KIND_NEXT + $urandom_range(0, 3));
            else kind = (r < 97) ? KIND_SPARE_LO : KIND_SPARE_HI;
            r = $urandom_range(0, 99);
            if (r < 75) key = 8'($urandom_range(1, pool));
            else if (r < 85) key = '0;
            else key = 8'($urandom_range(0, 255));
            // removes mostly target a key that is in the table
            if (kind == KIND_REMOVE && $urandom_range(0, 9) < 6)
               key = slot_key_q[$urandom_range(0, SLOT_COUNT - 1)];
            r = $urandom_range(0, 99);
            if (r < 35) init = 16'($urandom_range(0, 3));
            else if (r < 50) init = COUNT_MAX - 16'($urandom_range(0, 1));
            else init = 16'($urandom);
            send_request(kind, key, init);
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      foreach (slot_key_q[i]) begin
         slot_key_q[i]   = '0;
         slot_count_q[i] = '0;
      end
      cursor_q    = '0;
      row_width_q = 6'd5;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_basics();
      test_cursor_moves();
      test_full_table();
      test_random_traffic();

      wait_idle();
      $display("covered %0d requests over %0d row width settings, %0d cursor moves",
               n_requests, n_settings, n_moves);
      $display("adds stored %0d, refused when full %0d, saturated %0d, slots freed %0d",
               n_add_stored, n_add_refused, n_saturated, n_freed);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(CLOCK_PERIOD * 1000000);
      $error("run did not complete in time, %0d results outstanding",
             pending_results.size());
      $display("FAIL");
      $finish;
   end

endmodule
